>>> hw/rtl/tlnf_pkg.sv
// Shared types and constants for the text line number filter.
`timescale 1ns / 1ps

package tlnf_pkg;

  localparam int NUMBER_DIGITS_DEF = 6;
  localparam int QUEUE_DEPTH       = 4;
  localparam int CFG_INDEX_W       = 3;
  localparam int CFG_DATA_W        = 1;

  // Configuration register indexes
  localparam logic [CFG_INDEX_W-1:0] REG_NUMBER_NONBLANK = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_NUMBER_ALL      = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_SQUEEZE_BLANK   = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_SHOW_NONPRINT   = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_SHOW_TABS       = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] REG_SHOW_ENDS       = 3'd5;

  // Character codes
  localparam logic [7:0] CH_TAB    = 8'd9;
  localparam logic [7:0] CH_NL     = 8'd10;
  localparam logic [7:0] CH_SPACE  = 8'd32;
  localparam logic [7:0] CH_DOLLAR = 8'd36;
  localparam logic [7:0] CH_ZERO   = 8'd48;
  localparam logic [7:0] CH_QMARK  = 8'd63;
  localparam logic [7:0] CTRL_OFS  = 8'd64;
  localparam logic [7:0] CH_I      = 8'd73;
  localparam logic [7:0] CH_CARET  = 8'd94;
  localparam logic [7:0] CH_DEL    = 8'd127;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       new_file;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       last_of_run;
  } out_item_t;

  typedef struct packed {
    logic number_nonblank;
    logic number_all;
    logic squeeze_blank;
    logic show_nonprint;
    logic show_tabs;
    logic show_ends;
  } cfg_t;

  // Fixed part of one queued command; digits and blanking mask travel beside it
  typedef struct packed {
    logic       numbered;
    logic       caret;
    logic       dollar;
    logic [7:0] last_byte;
  } cmd_ctl_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

>>> hw/rtl/tlnf_front.sv
// Front end: accepts input bytes, tracks line state and builds output commands.
`timescale 1ns / 1ps

module tlnf_front #(
  parameter int NUMBER_DIGITS = tlnf_pkg::NUMBER_DIGITS_DEF,
  parameter int CMD_W         = $bits(tlnf_pkg::cmd_ctl_t) + 5 * NUMBER_DIGITS
) (
  input  logic                clk,
  input  logic                rst,
  input  tlnf_pkg::cfg_t      cfg,
  input  logic                in_valid,
  output logic                in_stall,
  input  tlnf_pkg::in_item_t  in_data,
  input  tlnf_pkg::q_stat_t   q_stat,
  output logic                push,
  output logic [CMD_W-1:0]    cmd
);
  import tlnf_pkg::*;

  localparam int BCD_W = 4 * NUMBER_DIGITS;

  logic [BCD_W-1:0]         line_num, line_num_next;
  logic                     at_start, at_start_next;
  logic                     prev_blank, prev_blank_next;

  logic [7:0]               c;
  logic                     nl, st_eff, drop, ctrl, acc;
  logic [BCD_W-1:0]         ln_eff;
  logic [NUMBER_DIGITS-1:0] blank;
  cmd_ctl_t                 ctl;

  // Saturating BCD increment
  function automatic logic [BCD_W-1:0] bcd_inc(input logic [BCD_W-1:0] v);
    logic [BCD_W-1:0] r;
    logic             carry;
    logic             all9;
    logic [3:0]       d;
    r     = v;
    carry = 1'b1;
    all9  = 1'b1;
    for (int i = 0; i < NUMBER_DIGITS; i++) begin
      d    = v[4*i +: 4];
      all9 = all9 & (d == 4'd9);
      if (carry) begin
        if (d == 4'd9) begin
          r[4*i +: 4] = 4'd0;
        end else begin
          r[4*i +: 4] = d + 4'd1;
          carry       = 1'b0;
        end
      end
    end
    return all9 ? v : r;
  endfunction

  always_comb begin
    c      = in_data.in_byte;
    nl     = (c == CH_NL);
    ln_eff = in_data.new_file ? BCD_W'(1) : line_num;
    st_eff = in_data.new_file | at_start;
    drop   = cfg.squeeze_blank && st_eff && prev_blank && nl;

    ctl.numbered = !drop && (cfg.number_nonblank ? (st_eff && !nl)
                                                 : (cfg.number_all && st_eff));
    ctrl          = ((c < CH_SPACE) || (c == CH_DEL)) && !nl && (c != CH_TAB);
    ctl.caret     = 1'b0;
    ctl.last_byte = c;
    if (cfg.show_nonprint && ctrl) begin
      ctl.caret     = 1'b1;
      ctl.last_byte = (c == CH_DEL) ? CH_QMARK : (c + CTRL_OFS);
    end
    if (cfg.show_tabs && (c == CH_TAB)) begin
      ctl.caret     = 1'b1;
      ctl.last_byte = CH_I;
    end
    ctl.dollar = cfg.show_ends && nl;

    // Blank leading zeros, never the units digit
    for (int i = 0; i < NUMBER_DIGITS; i++) begin
      blank[i] = (i != 0) && ((ln_eff >> (4 * i)) == '0);
    end

    in_stall = q_stat.full;
    acc      = in_valid && !q_stat.full;
    push     = acc && !drop;
    cmd      = {ctl, blank, ln_eff};

    line_num_next   = line_num;
    at_start_next   = at_start;
    prev_blank_next = prev_blank;
    if (acc) begin
      line_num_next   = ctl.numbered ? bcd_inc(ln_eff) : ln_eff;
      at_start_next   = nl;
      prev_blank_next = !nl ? 1'b0 : (st_eff ? 1'b1 : prev_blank);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      line_num   <= BCD_W'(1);
      at_start   <= 1'b1;
      prev_blank <= 1'b0;
    end else begin
      line_num   <= line_num_next;
      at_start   <= at_start_next;
      prev_blank <= prev_blank_next;
    end
  end

endmodule

>>> hw/rtl/tlnf_queue.sv
// Short command queue between the front end and the output sequencer.
`timescale 1ns / 1ps

module tlnf_queue #(
  parameter int WIDTH = 41,
  parameter int DEPTH = 4
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  logic [WIDTH-1:0]  din,
  input  logic              pop,
  output logic [WIDTH-1:0]  dout,
  output tlnf_pkg::q_stat_t stat
);
  import tlnf_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] entries [DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0] count;

  always_comb begin
    dout       = entries[rd_ptr];
    stat.full  = (count == CNT_W'(DEPTH));
    stat.empty = (count == '0);
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + CNT_W'(1);
      end else if (pop && !push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

endmodule

>>> hw/rtl/tlnf_back.sv
// Output sequencer: expands each queued command into output characters.
`timescale 1ns / 1ps

module tlnf_back #(
  parameter int NUMBER_DIGITS = tlnf_pkg::NUMBER_DIGITS_DEF,
  parameter int CMD_W         = $bits(tlnf_pkg::cmd_ctl_t) + 5 * NUMBER_DIGITS
) (
  input  logic                clk,
  input  logic                rst,
  input  logic [CMD_W-1:0]    cmd,
  input  tlnf_pkg::q_stat_t   q_stat,
  output logic                pop,
  output logic                out_valid,
  input  logic                out_stall,
  output tlnf_pkg::out_item_t out_data
);
  import tlnf_pkg::*;

  localparam int BCD_W = 4 * NUMBER_DIGITS;
  localparam int IDX_W = $clog2(NUMBER_DIGITS + 1);

  localparam logic [1:0] ST_NUM   = 2'd0;
  localparam logic [1:0] ST_CARET = 2'd1;
  localparam logic [1:0] ST_END   = 2'd2;
  localparam logic [1:0] ST_BYTE  = 2'd3;

  logic [1:0]               stage, stage_next, cur;
  logic [IDX_W-1:0]         idx, idx_next, dsel;
  cmd_ctl_t                 ctl;
  logic [NUMBER_DIGITS-1:0] blank;
  logic [BCD_W-1:0]         digits;
  logic [3:0]               dig;
  logic                     dig_blank, load;
  out_item_t                item;

  always_comb begin
    ctl    = cmd[CMD_W-1 -: $bits(cmd_ctl_t)];
    blank  = cmd[BCD_W +: NUMBER_DIGITS];
    digits = cmd[BCD_W-1:0];

    // Skip the parts this command does not have
    cur = stage;
    if (cur == ST_NUM && !ctl.numbered) cur = ST_CARET;
    if (cur == ST_CARET && !ctl.caret) cur = ST_END;
    if (cur == ST_END && !ctl.dollar) cur = ST_BYTE;

    // Digits go out most significant first
    dsel      = IDX_W'(NUMBER_DIGITS - 1) - idx;
    dig       = '0;
    dig_blank = 1'b0;
    for (int i = 0; i < NUMBER_DIGITS; i++) begin
      if (dsel == IDX_W'(i)) begin
        dig       = digits[4*i +: 4];
        dig_blank = blank[i];
      end
    end

    item.last_of_run = 1'b0;
    case (cur)
      ST_NUM: begin
        if (idx == IDX_W'(NUMBER_DIGITS)) item.out_byte = CH_TAB;
        else item.out_byte = dig_blank ? CH_SPACE : (CH_ZERO + {4'd0, dig});
      end
      ST_CARET: item.out_byte = CH_CARET;
      ST_END:   item.out_byte = CH_DOLLAR;
      default: begin
        item.out_byte    = ctl.last_byte;
        item.last_of_run = 1'b1;
      end
    endcase

    load = !q_stat.empty && (!out_valid || !out_stall);
    pop  = load && (cur == ST_BYTE);

    stage_next = stage;
    idx_next   = idx;
    if (load) begin
      case (cur)
        ST_NUM: begin
          if (idx == IDX_W'(NUMBER_DIGITS)) begin
            idx_next   = '0;
            stage_next = ST_CARET;
          end else begin
            idx_next = idx + IDX_W'(1);
          end
        end
        ST_CARET: stage_next = ST_END;
        ST_END:   stage_next = ST_BYTE;
        default: begin
          stage_next = ST_NUM;
          idx_next   = '0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stage     <= ST_NUM;
      idx       <= '0;
      out_valid <= 1'b0;
    end else begin
      stage <= stage_next;
      idx   <= idx_next;
      if (load) out_valid <= 1'b1;
      else if (!out_stall) out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) out_data <= item;
  end

endmodule

>>> hw/rtl/text_line_number_filter.sv
// Top level of the text line number filter: configuration, front end, queue, sequencer.
// An accepted input reaches the output through the command queue and the output register.
// Throughput: 1 input per cycle for plain bytes while out_stall is low. An input gives its
// byte plus NUMBER_DIGITS+1 characters for a line number, +1 for a caret, +1 for "$". The
// output sequencer emits one character per cycle while out_stall is low and sets the rate;
// the queue absorbs short expansions. Reset clears configuration, line state and the queue.
`timescale 1ns / 1ps

module text_line_number_filter #(
  parameter int NUMBER_DIGITS = tlnf_pkg::NUMBER_DIGITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  tlnf_pkg::in_item_t                  in_data,
  output logic                                out_valid,
  input  logic                                out_stall,
  output tlnf_pkg::out_item_t                 out_data,
  input  logic                                cfg_wr_en,
  input  logic [tlnf_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [tlnf_pkg::CFG_DATA_W-1:0]     cfg_data
);
  import tlnf_pkg::*;

  localparam int CMD_W = $bits(cmd_ctl_t) + 5 * NUMBER_DIGITS;

  cfg_t             cfg;
  q_stat_t          q_stat;
  logic             push, pop;
  logic [CMD_W-1:0] cmd_in, cmd_out;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_NUMBER_NONBLANK: cfg.number_nonblank <= cfg_data[0];
        REG_NUMBER_ALL:      cfg.number_all      <= cfg_data[0];
        REG_SQUEEZE_BLANK:   cfg.squeeze_blank   <= cfg_data[0];
        REG_SHOW_NONPRINT:   cfg.show_nonprint   <= cfg_data[0];
        REG_SHOW_TABS:       cfg.show_tabs       <= cfg_data[0];
        REG_SHOW_ENDS:       cfg.show_ends       <= cfg_data[0];
        default: ;
      endcase
    end
  end

  tlnf_front #(
    .NUMBER_DIGITS(NUMBER_DIGITS),
    .CMD_W        (CMD_W)
  ) u_front (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_data (in_data),
    .q_stat  (q_stat),
    .push    (push),
    .cmd     (cmd_in)
  );

  tlnf_queue #(
    .WIDTH(CMD_W),
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk (clk),
    .rst (rst),
    .push(push),
    .din (cmd_in),
    .pop (pop),
    .dout(cmd_out),
    .stat(q_stat)
  );

  tlnf_back #(
    .NUMBER_DIGITS(NUMBER_DIGITS),
    .CMD_W        (CMD_W)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd_out),
    .q_stat   (q_stat),
    .pop      (pop),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  a_no_pop_empty: assert property (@(posedge clk) disable iff (rst)
    pop |-> !q_stat.empty)
    else $error("command queue popped while empty");

  a_no_push_full: assert property (@(posedge clk) disable iff (rst)
    push |-> !q_stat.full)
    else $error("command queue pushed while full");

  a_drop_only_squeeze: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall && !push) |->
      (cfg.squeeze_blank && in_data.in_byte == CH_NL))
    else $error("transaction dropped outside a squeezed blank line");

  a_idle_after_reset: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("output valid right after reset");

endmodule
